>>> rtl/art_pkg.sv
package art_pkg;

    localparam int NUM_ANTENNAS_DEF = 64;
    localparam int TIMEOUT_W        = 28;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_REPLY = 3'd1;
    localparam logic [2:0] MODE_DELAY = 3'd2;
    localparam logic [2:0] MODE_ROT   = 3'd3;
    localparam logic [2:0] MODE_BOTH  = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    localparam logic [2:0] ST_UNINIT = 3'd0;
    localparam logic [2:0] ST_DELAY  = 3'd1;
    localparam logic [2:0] ST_ROT    = 3'd2;
    localparam logic [2:0] ST_BOTH   = 3'd3;
    localparam logic [2:0] ST_SETTLE = 3'd4;
    localparam logic [2:0] ST_VALID  = 3'd5;

    localparam logic [7:0]  WAIT_RESET  = 8'd5;
    localparam logic [19:0] CYCLE_RESET = 20'd5000;

    localparam logic REG_WAIT  = 1'b0;
    localparam logic REG_CYCLE = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [5:0]         antenna;
        logic [47:0]        time_now;
        logic [31:0]        reply_id;
        logic               has_apply_lo;
        logic               has_apply_hi;
        logic [31:0]        apply_lo;
        logic [31:0]        apply_hi;
        logic signed [31:0] delay;
        logic signed [31:0] rot_rate;
        logic signed [31:0] rot_slope;
        logic signed [31:0] rot_offset;
    } t_in;

    typedef struct packed {
        logic [5:0]         antenna_out;
        logic [2:0]         status;
        logic [31:0]        issued_id;
        logic signed [31:0] req_delay;
        logic signed [31:0] req_rate;
        logic signed [31:0] req_slope;
        logic signed [31:0] req_offset;
        logic [63:0]        apply_time;
        logic               matched;
        logic               bat_incomplete;
        logic [6:0]         unflag_count;
    } t_out;

    // one antenna entry of the record store
    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        tag;
        logic [47:0]        settle;
        logic signed [31:0] delay;
        logic signed [31:0] rate;
        logic signed [31:0] slope;
        logic signed [31:0] offset;
        logic [63:0]        bat;
    } t_rec;

    localparam t_rec REC_RESET = '{
        status: ST_UNINIT, tag: 32'd0, settle: 48'd0,
        delay: -32'sd1, rate: -32'sd1, slope: -32'sd1, offset: -32'sd1,
        bat: 64'd0};

endpackage

>>> rtl/art_store.sv
module art_store #(
    parameter int NUM_ANTENNAS = art_pkg::NUM_ANTENNAS_DEF,
    parameter int AW = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  art_pkg::t_rec   i_wrec,
    input  logic            i_wpend,
    input  logic [AW-1:0]   i_raddr,
    output art_pkg::t_rec   o_rrec,
    output logic            o_rpend
);

    art_pkg::t_rec r_mem [NUM_ANTENNAS];
    logic [NUM_ANTENNAS-1:0] r_init;
    logic [NUM_ANTENNAS-1:0] r_pend;
    art_pkg::t_rec r_rdata;
    logic          r_rinit;
    logic          r_rpend;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wrec;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= '0;
            r_pend  <= '0;
            r_rinit <= 1'b0;
            r_rpend <= 1'b0;
        end else begin
            if (i_we) begin
                r_init[i_waddr] <= 1'b1;
                r_pend[i_waddr] <= i_wpend;
            end
            r_rinit <= r_init[i_raddr];
            r_rpend <= r_pend[i_raddr];
        end
    end

    // an entry never written reads as its reset record
    assign o_rrec  = r_rinit ? r_rdata : art_pkg::REC_RESET;
    assign o_rpend = r_rpend;

endmodule

>>> rtl/art_eval.sv
module art_eval (
    input  art_pkg::t_in                       i_item,
    input  art_pkg::t_rec                      i_rec,
    input  logic                               i_pend,
    input  logic [7:0]                         i_wait,
    input  logic [art_pkg::TIMEOUT_W-1:0]      i_timeout,
    input  logic [47:0]                        i_latest,
    input  logic [31:0]                        i_msg,
    output logic                               o_hit,
    output logic                               o_we,
    output art_pkg::t_rec                      o_rec,
    output logic                               o_pend
);

    logic [48:0] diff;

    always_comb begin
        diff   = {1'b0, i_item.time_now} - {1'b0, i_rec.settle};
        o_rec  = i_rec;
        o_pend = i_pend;
        o_hit  = 1'b0;
        o_we   = 1'b0;
        case (i_item.mode)
            art_pkg::MODE_TICK: begin
                // borrow set means time_now is before the settle start
                if (i_rec.status == art_pkg::ST_SETTLE && !diff[48] &&
                    diff[47:0] >= 48'(i_timeout)) begin
                    o_hit        = 1'b1;
                    o_we         = 1'b1;
                    o_rec.status = art_pkg::ST_VALID;
                end
            end
            art_pkg::MODE_REPLY: begin
                if (i_pend && i_rec.tag == i_item.reply_id) begin
                    o_hit  = 1'b1;
                    o_we   = 1'b1;
                    o_pend = 1'b0;
                    if (i_item.has_apply_lo && i_item.has_apply_hi) begin
                        o_rec.bat = {i_item.apply_hi, i_item.apply_lo};
                    end
                    if (i_wait != 8'd0) begin
                        o_rec.status = art_pkg::ST_SETTLE;
                        o_rec.settle = i_latest;
                    end else begin
                        o_rec.status = art_pkg::ST_VALID;
                    end
                end
            end
            art_pkg::MODE_DELAY: begin
                o_hit        = 1'b1;
                o_we         = 1'b1;
                o_pend       = 1'b1;
                o_rec.tag    = i_msg;
                o_rec.delay  = i_item.delay;
                o_rec.status = art_pkg::ST_DELAY;
            end
            art_pkg::MODE_ROT: begin
                o_hit        = 1'b1;
                o_we         = 1'b1;
                o_pend       = 1'b1;
                o_rec.tag    = i_msg;
                o_rec.rate   = i_item.rot_rate;
                o_rec.slope  = i_item.rot_slope;
                o_rec.offset = i_item.rot_offset;
                o_rec.status = art_pkg::ST_ROT;
            end
            art_pkg::MODE_BOTH: begin
                o_hit        = 1'b1;
                o_we         = 1'b1;
                o_pend       = 1'b1;
                o_rec.tag    = i_msg;
                o_rec.delay  = i_item.delay;
                o_rec.rate   = i_item.rot_rate;
                o_rec.slope  = i_item.rot_slope;
                o_rec.offset = i_item.rot_offset;
                o_rec.status = art_pkg::ST_BOTH;
            end
            art_pkg::MODE_READ: begin
                o_hit = 1'b1;
            end
            default: begin
                o_hit = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/antenna_request_tracker_unit.sv
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   i_in  (art_pkg::t_in)
// result    out        o_out_valid / i_out_ready o_out (art_pkg::t_out)
// config    in         psel/penable/pwrite       paddr, pwdata, prdata
//
// tick and reply sweep the record memory one entry a cycle, tick after a
// timeout multiply step; request and read visit only the addressed entry.
// the sweep length is set by the single read and write port of the memory.
// synchronous active-low reset; record memory needs no clearing pass.
// the result register lets a new item start while a result waits; a
// finished item holds in the done state until the result register is free.
module antenna_request_tracker_unit #(
    parameter int NUM_ANTENNAS = art_pkg::NUM_ANTENNAS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  art_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output art_pkg::t_out o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = (NUM_ANTENNAS > 1) ? $clog2(NUM_ANTENNAS) : 1;
    localparam int CW = $clog2(NUM_ANTENNAS + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ANTENNAS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                      r_state;
    art_pkg::t_in                    r_item;
    logic [AW-1:0]                   r_ridx;
    logic [AW-1:0]                   r_last;
    logic                            r_issue;
    logic                            r_dv;
    logic [AW-1:0]                   r_didx;
    logic                            r_found;
    logic [CW-1:0]                   r_count;
    art_pkg::t_out                   r_res;
    logic [art_pkg::TIMEOUT_W-1:0]   r_timeout;
    logic [31:0]                     r_msg;
    logic [47:0]                     r_latest;
    logic [7:0]                      r_wait;
    logic [19:0]                     r_cyc;
    logic                            r_out_valid;
    art_pkg::t_out                   r_out;

    art_pkg::t_rec rd_rec;
    logic          rd_pend;
    art_pkg::t_rec ev_rec;
    logic          ev_pend;
    logic          ev_hit;
    logic          ev_we;
    logic          in_xfer;
    logic          ant_ok;
    logic          is_req;
    art_pkg::t_out res_init;
    art_pkg::t_out res_done;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign ant_ok      = 32'(i_in.antenna) < NUM_ANTENNAS;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == art_pkg::REG_CYCLE) ? {12'd0, r_cyc} : {24'd0, r_wait};
    assign is_req      = (r_item.mode == art_pkg::MODE_DELAY) ||
                         (r_item.mode == art_pkg::MODE_ROT) ||
                         (r_item.mode == art_pkg::MODE_BOTH);

    // out-of-range request or read reports only the antenna index
    always_comb begin
        res_init = '0;
        if (!ant_ok && i_in.mode >= art_pkg::MODE_DELAY &&
            i_in.mode <= art_pkg::MODE_READ) begin
            res_init.antenna_out = i_in.antenna;
        end
    end

    always_comb begin
        res_done              = r_res;
        res_done.unflag_count = 7'(r_count);
    end

    art_store #(.NUM_ANTENNAS(NUM_ANTENNAS), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_dv && ev_we),
        .i_waddr (r_didx),
        .i_wrec  (ev_rec),
        .i_wpend (ev_pend),
        .i_raddr (r_ridx),
        .o_rrec  (rd_rec),
        .o_rpend (rd_pend)
    );

    art_eval u_eval (
        .i_item    (r_item),
        .i_rec     (rd_rec),
        .i_pend    (rd_pend),
        .i_wait    (r_wait),
        .i_timeout (r_timeout),
        .i_latest  (r_latest),
        .i_msg     (r_msg),
        .o_hit     (ev_hit),
        .o_we      (ev_we),
        .o_rec     (ev_rec),
        .o_pend    (ev_pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_msg       <= 32'd1;
            r_latest    <= 48'd0;
            r_wait      <= art_pkg::WAIT_RESET;
            r_cyc       <= art_pkg::CYCLE_RESET;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == art_pkg::REG_CYCLE) begin
                    r_cyc <= pwdata[19:0];
                end else begin
                    r_wait <= pwdata[7:0];
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // read data for r_ridx comes back in the next cycle
            r_dv   <= (r_state == S_RUN) && r_issue;
            r_didx <= r_ridx;
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_item  <= i_in;
                        r_res   <= res_init;
                        r_found <= 1'b0;
                        r_count <= '0;
                        case (i_in.mode)
                            art_pkg::MODE_TICK: begin
                                r_latest <= i_in.time_now;
                                r_state  <= S_MUL;
                            end
                            art_pkg::MODE_REPLY: begin
                                r_ridx  <= '0;
                                r_last  <= LAST_IDX;
                                r_issue <= 1'b1;
                                r_state <= S_RUN;
                            end
                            art_pkg::MODE_DELAY, art_pkg::MODE_ROT,
                            art_pkg::MODE_BOTH, art_pkg::MODE_READ: begin
                                if (ant_ok) begin
                                    r_ridx  <= AW'(i_in.antenna);
                                    r_last  <= AW'(i_in.antenna);
                                    r_issue <= 1'b1;
                                    r_state <= S_RUN;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_timeout <= art_pkg::TIMEOUT_W'(r_wait) * art_pkg::TIMEOUT_W'(r_cyc);
                    r_ridx    <= '0;
                    r_last    <= LAST_IDX;
                    r_issue   <= 1'b1;
                    r_state   <= S_RUN;
                end
                S_RUN: begin
                    if (r_issue) begin
                        if (r_ridx == r_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_ridx <= r_ridx + 1'b1;
                        end
                    end
                    if (r_dv) begin
                        if (ev_hit) begin
                            if (r_item.mode == art_pkg::MODE_TICK) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (!r_found) begin
                                r_found            <= 1'b1;
                                r_res.antenna_out  <= 6'(r_didx);
                                r_res.status       <= ev_rec.status;
                                r_res.req_delay    <= ev_rec.delay;
                                r_res.req_rate     <= ev_rec.rate;
                                r_res.req_slope    <= ev_rec.slope;
                                r_res.req_offset   <= ev_rec.offset;
                                r_res.apply_time   <= ev_rec.bat;
                                if (r_item.mode == art_pkg::MODE_REPLY) begin
                                    r_res.matched        <= 1'b1;
                                    r_res.bat_incomplete <= r_item.has_apply_lo ^
                                                            r_item.has_apply_hi;
                                end
                                if (is_req) begin
                                    r_res.issued_id <= r_msg;
                                    r_msg           <= r_msg + 32'd1;
                                end
                            end
                        end
                        if (r_didx == r_last) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= res_done;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/art_checker.sv
module art_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input art_pkg::t_out o_out,
    input logic          pready
);

    // a result waiting for transfer stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed while stalled");

    // one item at a time: no transfer in the cycle after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

    // incomplete apply time is only flagged on a matched reply
    a_bat_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.bat_incomplete |-> o_out.matched &&
        o_out.issued_id == 32'd0 && o_out.unflag_count == 7'd0)
        else $error("incomplete flag without a matched reply");

    // an issued id belongs to a request, never to a reply or tick
    a_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.issued_id != 32'd0 |->
        !o_out.matched && o_out.unflag_count == 7'd0)
        else $error("issued id on a non-request result");

endmodule

bind antenna_request_tracker_unit art_checker u_art_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .pready      (pready)
);
